// File: hw/rtl/iqpd_pkg.sv
// shared types, constants and the arctangent table for the iq phase difference block
// no dependencies; used by iqpd_ctrl, iqpd_datapath and iq_phase_difference_top

package iqpd_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int ACC_W        = 36;
   localparam int PHASE_W      = 16;
   localparam int FRAC_BITS    = 13;
   localparam int ANGLE_FRAC   = 32;
   localparam int ROUND_SHIFT  = ANGLE_FRAC - FRAC_BITS;
   localparam int RES_W        = ACC_W + 1 - ROUND_SHIFT;
   localparam int ITERS        = 16;
   localparam int STEP_W       = 4;
   localparam int MUL_STEPS    = 4;

   localparam longint PI_VAL = 64'sd13493037705;
   localparam logic signed [ACC_W-1:0] PI_Q32 = ACC_W'(PI_VAL);
   localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(longint'(1) << (ROUND_SHIFT - 1));
   localparam logic signed [RES_W-1:0] PHASE_LIM =
      RES_W'((PI_VAL + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);

   // product select codes for the shared multiplier
   localparam logic [1:0] SEL_II = 2'd0;
   localparam logic [1:0] SEL_QQ = 2'd1;
   localparam logic [1:0] SEL_QI = 2'd2;
   localparam logic [1:0] SEL_IQ = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PRE,
      ST_ITER,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              load;
      logic              mul_en;
      logic [1:0]        mul_sel;
      logic              pre;
      logic              iter_en;
      logic [STEP_W-1:0] iter_k;
      logic              finish;
   } cmd_type;

   // atan(2^-k) in radians, 32 fraction bits, rounded to nearest
   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [STEP_W-1:0] k);
      logic signed [ACC_W-1:0] v;
      case (k)
         4'd0:    v = 36'sd3373259426;
         4'd1:    v = 36'sd1991351318;
         4'd2:    v = 36'sd1052175346;
         4'd3:    v = 36'sd534100635;
         4'd4:    v = 36'sd268086748;
         4'd5:    v = 36'sd134174063;
         4'd6:    v = 36'sd67103403;
         4'd7:    v = 36'sd33553749;
         4'd8:    v = 36'sd16777131;
         4'd9:    v = 36'sd8388597;
         4'd10:   v = 36'sd4194303;
         4'd11:   v = 36'sd2097152;
         4'd12:   v = 36'sd1048576;
         4'd13:   v = 36'sd524288;
         4'd14:   v = 36'sd262144;
         4'd15:   v = 36'sd131072;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: hw/rtl/iqpd_ctrl.sv
// sequencer for the iq phase difference block: handshakes and step counting
// depends on iqpd_pkg; drives the command struct of iqpd_datapath

module iqpd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output iqpd_pkg::cmd_type cmd
);

   iqpd_pkg::state_type state_ff, state_in;
   logic [iqpd_pkg::STEP_W-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iqpd_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == iqpd_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.mul_sel  = step_ff[1:0];
      cmd.iter_k   = step_ff;
      case (state_ff)
         iqpd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = iqpd_pkg::ST_MUL;
            end
         end
         iqpd_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == iqpd_pkg::STEP_W'(iqpd_pkg::MUL_STEPS - 1)) begin
               state_in = iqpd_pkg::ST_PRE;
            end
         end
         iqpd_pkg::ST_PRE: begin
            cmd.pre  = 1'b1;
            step_in  = '0;
            state_in = iqpd_pkg::ST_ITER;
         end
         iqpd_pkg::ST_ITER: begin
            cmd.iter_en = 1'b1;
            step_in     = step_ff + 1'b1;
            if (step_ff == iqpd_pkg::STEP_W'(iqpd_pkg::ITERS - 1)) begin
               state_in = iqpd_pkg::ST_DONE;
            end
         end
         iqpd_pkg::ST_DONE: begin
            // wait until the output register can take the new item
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = iqpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iqpd_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == iqpd_pkg::ST_MUL && step_ff == '0))
      else $error("accepted item did not start the multiply sequence");

   a_last_iter_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iqpd_pkg::ST_ITER &&
       step_ff == iqpd_pkg::STEP_W'(iqpd_pkg::ITERS - 1)) |=> (state_ff == iqpd_pkg::ST_DONE))
      else $error("cordic did not finish after the last iteration");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iqpd_pkg::ST_DONE && out_free) |=> rsp_valid_ff)
      else $error("finished item not presented on the output");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != iqpd_pkg::ST_IDLE) |-> !req_tready)
      else $error("ready raised while an item is in progress");
`endif

endmodule

// File: hw/rtl/iqpd_datapath.sv
// datapath: conjugate product on one shared multiplier, iterative cordic, output rounding
// depends on iqpd_pkg; sequenced by iqpd_ctrl through the command struct

module iqpd_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  iqpd_pkg::cmd_type                    cmd,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wdata,
   input  logic signed [iqpd_pkg::SAMPLE_W-1:0] i_sample,
   input  logic signed [iqpd_pkg::SAMPLE_W-1:0] q_sample,
   output logic signed [iqpd_pkg::PHASE_W-1:0]  phase
);

   localparam int AW = iqpd_pkg::ACC_W;
   localparam int RW = iqpd_pkg::RES_W;

   logic mode_ff;
   logic signed [iqpd_pkg::SAMPLE_W-1:0] prev_i_ff, prev_q_ff, cur_i_ff, cur_q_ff;
   logic signed [AW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic zero_ff, zero_in;
   logic signed [iqpd_pkg::PHASE_W-1:0] phase_ff, phase_in;

   logic signed [iqpd_pkg::SAMPLE_W-1:0] mul_a, mul_b;
   logic signed [iqpd_pkg::PROD_W-1:0] prod;
   logic signed [AW-1:0] prod_ext, dx, dy;
   logic signed [AW:0] z_rnd;
   logic signed [RW-1:0] r_raw, r_clamp, r_mag, r_whole, r_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         prev_i_ff <= '0;
         prev_q_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wdata;
         end
         // last product used, current sample becomes the previous one
         if (cmd.mul_en && cmd.mul_sel == iqpd_pkg::SEL_IQ) begin
            prev_i_ff <= cur_i_ff;
            prev_q_ff <= cur_q_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_i_ff <= i_sample;
         cur_q_ff <= q_sample;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      zero_ff  <= zero_in;
      phase_ff <= phase_in;
   end

   // one shared multiplier, four passes
   always_comb begin
      mul_a = (cmd.mul_sel == iqpd_pkg::SEL_II || cmd.mul_sel == iqpd_pkg::SEL_IQ)
              ? cur_i_ff : cur_q_ff;
      mul_b = (cmd.mul_sel == iqpd_pkg::SEL_II || cmd.mul_sel == iqpd_pkg::SEL_QI)
              ? prev_i_ff : prev_q_ff;
      prod     = mul_a * mul_b;
      prod_ext = {{(AW - iqpd_pkg::PROD_W){prod[iqpd_pkg::PROD_W-1]}}, prod};
      dx       = y_ff >>> cmd.iter_k;
      dy       = x_ff >>> cmd.iter_k;
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            iqpd_pkg::SEL_II: x_in = prod_ext;
            iqpd_pkg::SEL_QQ: x_in = x_ff + prod_ext;
            iqpd_pkg::SEL_QI: y_in = prod_ext;
            iqpd_pkg::SEL_IQ: y_in = y_ff - prod_ext;
            default:          x_in = x_ff;
         endcase
      end else if (cmd.pre) begin
         zero_in = (x_ff == '0) && (y_ff == '0);
         // left half plane: fold over and start from +-pi
         if (x_ff[AW-1]) begin
            z_in = y_ff[AW-1] ? -iqpd_pkg::PI_Q32 : iqpd_pkg::PI_Q32;
            x_in = -x_ff;
            y_in = -y_ff;
         end else begin
            z_in = '0;
         end
      end else if (cmd.iter_en) begin
         if (!y_ff[AW-1]) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + iqpd_pkg::atan_entry(cmd.iter_k);
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - iqpd_pkg::atan_entry(cmd.iter_k);
         end
      end
   end

   // round half up to the output format, clamp to +-pi, optional whole radians
   always_comb begin
      z_rnd = $signed({z_ff[AW-1], z_ff}) + iqpd_pkg::ROUND_HALF;
      r_raw = z_rnd[AW:iqpd_pkg::ROUND_SHIFT];
      if (r_raw > iqpd_pkg::PHASE_LIM) begin
         r_clamp = iqpd_pkg::PHASE_LIM;
      end else if (r_raw < -iqpd_pkg::PHASE_LIM) begin
         r_clamp = -iqpd_pkg::PHASE_LIM;
      end else begin
         r_clamp = r_raw;
      end
      r_mag   = r_clamp[RW-1] ? -r_clamp : r_clamp;
      r_whole = r_mag >>> iqpd_pkg::FRAC_BITS;
      if (mode_ff) begin
         r_out = r_clamp[RW-1] ? -r_whole : r_whole;
      end else begin
         r_out = r_clamp;
      end
      phase_in = phase_ff;
      if (cmd.finish) begin
         phase_in = zero_ff ? '0 : r_out[iqpd_pkg::PHASE_W-1:0];
      end
   end

   assign phase = phase_ff;

endmodule

// File: hw/rtl/iq_phase_difference_top.sv
// top level of the iq phase difference (fm polar discriminator) block
// depends on iqpd_pkg, iqpd_ctrl and iqpd_datapath

// Each input item is one signed I/Q sample; each result item is the phase of
// that sample times the conjugate of the previous one (zero after reset), in
// radians with 13 fraction bits, or truncated to whole radians when the
// output mode bit is set. A zero product gives phase 0. Each item goes
// through these steps until its result is loaded into the output register:
// acceptance, four passes through the single 16x16 multiplier, one quadrant
// fold, sixteen cordic iterations on one shift-add unit and rounding, which
// waits while the output register still holds a result not yet taken.
// The next item is accepted as soon as the result has moved to the output
// register, even while that result still waits to be taken.
// Write the mode bit only while the block is idle.

module iq_phase_difference_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] i_sample, [31:16] q_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] phase
);

   iqpd_pkg::cmd_type cmd;
   logic signed [iqpd_pkg::PHASE_W-1:0] phase;

   iqpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   iqpd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_wr_en (csr_wr_en),
      .csr_wdata (csr_wdata),
      .i_sample  ($signed(req_tdata[15:0])),
      .q_sample  ($signed(req_tdata[31:16])),
      .phase     (phase)
   );

   assign rsp_tdata = phase;

endmodule
